[rtl/tcw_pkg.sv]
package tcw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int NCELLS = COLS * ROWS;
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CELL_W = $clog2(NCELLS);

    localparam logic [7:0] NEWLINE_CODE   = 8'd10;
    localparam logic [7:0] LAST_COLOR_RST = 8'h0f;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_BG    = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef struct packed {
        t_req              req_type;
        logic [7:0]        char_code;
        logic [7:0]        color;
        logic [3:0]        background;
        logic [CELL_W-1:0] cell_index;
    } t_in_word;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [CELL_W-1:0] cursor_pos;
        logic [7:0]        cell_char;
        logic [7:0]        cell_attr;
        logic              scrolled;
    } t_out_word;

    // microprogram addresses
    typedef logic [3:0] t_step;
    localparam t_step ST_INIT   = 4'd0;
    localparam t_step ST_IDLE   = 4'd1;
    localparam t_step ST_PUT    = 4'd2;
    localparam t_step ST_SCR_RD = 4'd3;
    localparam t_step ST_SCR_WR = 4'd4;
    localparam t_step ST_FILL   = 4'd5;
    localparam t_step ST_CLEAR  = 4'd6;
    localparam t_step ST_BG     = 4'd7;
    localparam t_step ST_READ   = 4'd8;
    localparam t_step ST_RESULT = 4'd9;

    typedef enum logic [1:0] {CS_ZERO, CS_PUT, CS_COPY} t_csrc;
    typedef enum logic [1:0] {AS_ZERO, AS_COLOR, AS_BG, AS_COPY} t_asrc;
    typedef enum logic {WS_CURSOR, WS_ADDR} t_wsel;
    typedef enum logic {RS_NEXT_ROW, RS_INDEX} t_rsel;
    typedef enum logic [1:0] {CU_HOLD, CU_ADVANCE, CU_HOME} t_curs;
    typedef enum logic {LIM_LAST, LIM_COPY} t_limit;
    // C_LOOP: at limit go to target, else repeat
    // C_COPY: at limit go to next, else back one step
    // C_SCROLL: scroll goes to next, else target
    typedef enum logic [2:0] {
        C_NEXT, C_LOOP, C_COPY, C_ACCEPT, C_SCROLL, C_OUT
    } t_cond;

    typedef struct packed {
        logic   char_we;
        t_csrc  csrc;
        logic   attr_we;
        t_asrc  asrc;
        logic   put_gate;
        t_wsel  wsel;
        logic   rd_en;
        t_rsel  rsel;
        logic   addr_inc;
        logic   addr_clr;
        t_curs  curs;
        t_cond  cond;
        t_limit limit;
        logic   out_load;
        t_step  target;
    } t_uop;

    function automatic t_uop uop_rom(t_step s);
        t_uop u;
        u = '0;
        case (s)
            ST_INIT: begin
                u.char_we  = 1'b1;
                u.attr_we  = 1'b1;
                u.wsel     = WS_ADDR;
                u.addr_inc = 1'b1;
                u.cond     = C_LOOP;
                u.limit    = LIM_LAST;
                u.target   = ST_IDLE;
            end
            ST_IDLE: begin
                u.addr_clr = 1'b1;
                u.cond     = C_ACCEPT;
            end
            ST_PUT: begin
                u.char_we  = 1'b1;
                u.csrc     = CS_PUT;
                u.attr_we  = 1'b1;
                u.asrc     = AS_COLOR;
                u.put_gate = 1'b1;
                u.wsel     = WS_CURSOR;
                u.curs     = CU_ADVANCE;
                u.cond     = C_SCROLL;
                u.target   = ST_RESULT;
            end
            ST_SCR_RD: begin
                u.rd_en = 1'b1;
                u.rsel  = RS_NEXT_ROW;
                u.cond  = C_NEXT;
            end
            ST_SCR_WR: begin
                u.char_we  = 1'b1;
                u.csrc     = CS_COPY;
                u.attr_we  = 1'b1;
                u.asrc     = AS_COPY;
                u.wsel     = WS_ADDR;
                u.addr_inc = 1'b1;
                u.cond     = C_COPY;
                u.limit    = LIM_COPY;
            end
            ST_FILL: begin
                u.char_we  = 1'b1;
                u.attr_we  = 1'b1;
                u.asrc     = AS_COLOR;
                u.wsel     = WS_ADDR;
                u.addr_inc = 1'b1;
                u.cond     = C_LOOP;
                u.limit    = LIM_LAST;
                u.target   = ST_RESULT;
            end
            ST_CLEAR: begin
                u.char_we  = 1'b1;
                u.wsel     = WS_ADDR;
                u.addr_inc = 1'b1;
                u.curs     = CU_HOME;
                u.cond     = C_LOOP;
                u.limit    = LIM_LAST;
                u.target   = ST_RESULT;
            end
            ST_BG: begin
                u.attr_we  = 1'b1;
                u.asrc     = AS_BG;
                u.wsel     = WS_ADDR;
                u.addr_inc = 1'b1;
                u.cond     = C_LOOP;
                u.limit    = LIM_LAST;
                u.target   = ST_RESULT;
            end
            ST_READ: begin
                u.rd_en = 1'b1;
                u.rsel  = RS_INDEX;
                u.cond  = C_NEXT;
            end
            ST_RESULT: begin
                u.out_load = 1'b1;
                u.cond     = C_OUT;
                u.target   = ST_IDLE;
            end
            default: begin
                u.cond   = C_LOOP;
                u.limit  = LIM_LAST;
                u.target = ST_IDLE;
            end
        endcase
        return u;
    endfunction

    function automatic t_step dispatch(t_req r);
        t_step s;
        case (r)
            REQ_PUT:   s = ST_PUT;
            REQ_CLEAR: s = ST_CLEAR;
            REQ_BG:    s = ST_BG;
            REQ_READ:  s = ST_READ;
            default:   s = ST_RESULT;
        endcase
        return s;
    endfunction

endpackage

[rtl/tcw_if.sv]
interface tcw_in_if;
    logic               valid;
    logic               ready;
    tcw_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcw_out_if;
    logic               valid;
    logic               ready;
    tcw_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/text_console_writer.sv]
// channel  | dir | word        | handshake
// ---------+-----+-------------+--------------------
// i_in     | in  | t_in_word   | valid/ready, sink
// o_out    | out | t_out_word  | valid/ready, source
//
// Clear and set background each write all NCELLS cells in a loop; a put that scrolls copies
// NCELLS-COLS cells up one row (copy loop reads then writes one cell), then fills the last COLS cells.
// The single read port of the cell store paces the scroll copy; fill loops write one cell a cycle.
// After reset a clearing pass writes zero over all NCELLS cells before the first word is taken.
// A result waits in the output register; the next word is taken while it waits,
// and only the result step stalls on o_out.ready.
module text_console_writer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcw_in_if.sink     i_in,
    tcw_out_if.source  o_out
);

    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int CELL_W = tcw_pkg::CELL_W;

    logic [7:0] char_mem [tcw_pkg::NCELLS];
    logic [7:0] attr_mem [tcw_pkg::NCELLS];

    tcw_pkg::t_step r_step, n_step;
    logic [CELL_W-1:0] r_addr;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [7:0]        r_last_color;
    tcw_pkg::t_req     r_req;
    logic [7:0]        r_char;
    logic [7:0]        r_color;
    logic [3:0]        r_bg;
    logic [CELL_W-1:0] r_index;
    logic              r_rd_ok;
    logic              r_scrolled;
    logic [7:0]        r_char_q;
    logic [7:0]        r_attr_q;
    logic              r_out_valid;
    tcw_pkg::t_out_word r_out;

    tcw_pkg::t_uop     uop;
    logic              in_acc;
    logic              out_free;
    logic [CELL_W-1:0] cur_pos;
    logic              is_nl;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic              wrap;
    logic [COL_W-1:0]  adv_col;
    logic [ROW_W:0]    adv_row_raw;
    logic              scroll;
    logic [ROW_W-1:0]  adv_row;
    logic              at_limit;
    logic [CELL_W-1:0] limit_val;
    logic              char_we;
    logic              attr_we;
    logic [CELL_W-1:0] wr_addr;
    logic [CELL_W-1:0] rd_addr;
    logic [7:0]        char_wdata;
    logic [7:0]        attr_wdata;

    assign uop      = tcw_pkg::uop_rom(r_step);
    assign i_in.ready = (uop.cond == tcw_pkg::C_ACCEPT);
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign cur_pos = CELL_W'(32'(r_row) * tcw_pkg::COLS) + CELL_W'(r_col);

    // cursor advance for a put
    always_comb begin
        is_nl       = (r_char == tcw_pkg::NEWLINE_CODE);
        col_inc     = {1'b0, r_col} + 1'b1;
        row_inc     = {1'b0, r_row} + 1'b1;
        wrap        = is_nl || (col_inc == (COL_W+1)'(tcw_pkg::COLS));
        adv_col     = wrap ? '0 : col_inc[COL_W-1:0];
        adv_row_raw = wrap ? row_inc : {1'b0, r_row};
        scroll      = (adv_row_raw == (ROW_W+1)'(tcw_pkg::ROWS));
        adv_row     = scroll ? ROW_W'(tcw_pkg::ROWS - 1) : adv_row_raw[ROW_W-1:0];
    end

    always_comb begin
        limit_val = (uop.limit == tcw_pkg::LIM_LAST) ? CELL_W'(tcw_pkg::NCELLS - 1)
                                                     : CELL_W'(tcw_pkg::NCELLS - tcw_pkg::COLS - 1);
        at_limit  = (r_addr == limit_val);
    end

    always_comb begin
        case (uop.cond)
            tcw_pkg::C_NEXT:   n_step = r_step + 1'b1;
            tcw_pkg::C_LOOP:   n_step = at_limit ? uop.target : r_step;
            tcw_pkg::C_COPY:   n_step = at_limit ? r_step + 1'b1 : r_step - 1'b1;
            tcw_pkg::C_ACCEPT: n_step = in_acc ? tcw_pkg::dispatch(i_in.data.req_type) : r_step;
            tcw_pkg::C_SCROLL: n_step = scroll ? r_step + 1'b1 : uop.target;
            tcw_pkg::C_OUT:    n_step = out_free ? uop.target : r_step;
            default:           n_step = tcw_pkg::ST_IDLE;
        endcase
    end

    // datapath selects
    always_comb begin
        char_we = uop.char_we && !(uop.put_gate && is_nl);
        attr_we = uop.attr_we && !(uop.put_gate && is_nl);
        wr_addr = (uop.wsel == tcw_pkg::WS_CURSOR) ? cur_pos : r_addr;
        if (uop.rsel == tcw_pkg::RS_INDEX) begin
            rd_addr = r_rd_ok ? r_index : '0;
        end else begin
            rd_addr = r_addr + CELL_W'(tcw_pkg::COLS);
        end
        case (uop.csrc)
            tcw_pkg::CS_PUT:  char_wdata = r_char;
            tcw_pkg::CS_COPY: char_wdata = r_char_q;
            default:          char_wdata = '0;
        endcase
        case (uop.asrc)
            tcw_pkg::AS_COLOR: attr_wdata = r_color;
            tcw_pkg::AS_BG:    attr_wdata = {r_bg, r_last_color[3:0]};
            tcw_pkg::AS_COPY:  attr_wdata = r_attr_q;
            default:           attr_wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (char_we) begin
            char_mem[wr_addr] <= char_wdata;
        end
        if (attr_we) begin
            attr_mem[wr_addr] <= attr_wdata;
        end
        if (uop.rd_en) begin
            r_char_q <= char_mem[rd_addr];
            r_attr_q <= attr_mem[rd_addr];
        end
    end

    // latched request
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req   <= i_in.data.req_type;
            r_char  <= i_in.data.char_code;
            r_color <= i_in.data.color;
            r_bg    <= i_in.data.background;
            r_index <= i_in.data.cell_index;
            r_rd_ok <= (32'(i_in.data.cell_index) < tcw_pkg::NCELLS);
        end
        if (uop.out_load && out_free) begin
            r_out.cursor_col <= r_col;
            r_out.cursor_row <= r_row;
            r_out.cursor_pos <= cur_pos;
            r_out.cell_char  <= (r_req == tcw_pkg::REQ_READ && r_rd_ok) ? r_char_q : 8'd0;
            r_out.cell_attr  <= (r_req == tcw_pkg::REQ_READ && r_rd_ok) ? r_attr_q : 8'd0;
            r_out.scrolled   <= r_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= tcw_pkg::ST_INIT;
            r_addr       <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_last_color <= tcw_pkg::LAST_COLOR_RST;
            r_scrolled   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_step <= n_step;
            if (uop.addr_clr) begin
                r_addr <= '0;
            end else if (uop.addr_inc) begin
                r_addr <= r_addr + 1'b1;
            end
            if (in_acc) begin
                r_scrolled <= 1'b0;
            end
            case (uop.curs)
                tcw_pkg::CU_ADVANCE: begin
                    r_col        <= adv_col;
                    r_row        <= adv_row;
                    r_scrolled   <= scroll;
                    r_last_color <= r_color;
                end
                tcw_pkg::CU_HOME: begin
                    r_col <= '0;
                    r_row <= '0;
                end
                default: begin
                end
            endcase
            if (uop.out_load && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < tcw_pkg::COLS)
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < tcw_pkg::ROWS)
        else $error("cursor row out of range");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.scrolled) |->
            (o_out.data.cursor_row == ROW_W'(tcw_pkg::ROWS - 1)))
        else $error("scrolled result not on last row");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == tcw_pkg::ST_IDLE) |-> (!char_we && !attr_we))
        else $error("cell store written while idle");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_step != tcw_pkg::ST_IDLE))
        else $error("accepted word did not start a program");

endmodule
